// File: rtl/rrce_pkg.sv
// Shared types, codes and a helper function for the record ring cursor engine.
package rrce_pkg;

  localparam int unsigned RING_BYTES_DEF = 4096;
  localparam int unsigned HDR_BYTES      = 32;

  typedef enum logic [2:0] {
    ACT_WRITE    = 3'd0,
    ACT_READ     = 3'd1,
    ACT_SHUT_TX  = 3'd2,
    ACT_SHUT_RX  = 3'd3,
    ACT_QUERY    = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    SOCK_STREAM  = 2'd0,
    SOCK_DGRAM   = 2'd1,
    SOCK_SEQPKT  = 2'd2,
    SOCK_BAD     = 2'd3
  } sock_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_AGAIN   = 3'd1,
    ST_INVALID = 3'd2,
    ST_PIPE    = 3'd3,
    ST_MSGSIZE = 3'd4,
    ST_PROTO   = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_USED,
    S_EXEC,
    S_RHDR,
    S_QREQ,
    S_QHDR,
    S_QFIN,
    S_SPAN,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t      status;
    logic [11:0]  payload_offset;
    logic [11:0]  first_span;
    logic [11:0]  second_span;
    logic [12:0]  byte_count;
    logic [63:0]  ticket_out;
    logic [63:0]  operation_out;
    logic [11:0]  record_len;
    logic         truncated;
    logic         eof;
    logic         readable;
    logic         writable;
  } result_t;

  // Record footprint: header plus payload, rounded up to 32 bytes.
  function automatic logic [31:0] rec_size(input logic [31:0] len);
    logic [31:0] sum;
    sum = len + 32'd63;
    return sum & ~32'd31;
  endfunction

endpackage

// File: rtl/rrce_hdr_mem.sv
// Record header store: length, ticket and operation word per 32-byte slot.
module rrce_hdr_mem #(
  parameter int unsigned SLOT_W = 7,
  parameter int unsigned LEN_W  = 12
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] addr,
  input  logic [LEN_W-1:0]  wr_len,
  input  logic [63:0]       wr_ticket,
  input  logic [63:0]       wr_op,
  output logic [LEN_W-1:0]  rd_len,
  output logic [63:0]       rd_ticket,
  output logic [63:0]       rd_op
);

  logic [LEN_W-1:0] mem_len    [2**SLOT_W];
  logic [63:0]      mem_ticket [2**SLOT_W];
  logic [63:0]      mem_op     [2**SLOT_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_len[addr]    <= wr_len;
      mem_ticket[addr] <= wr_ticket;
      mem_op[addr]     <= wr_op;
    end
    if (rd_en) begin
      rd_len    <= mem_len[addr];
      rd_ticket <= mem_ticket[addr];
      rd_op     <= mem_op[addr];
    end
  end

endmodule

// File: rtl/rrce_ctrl.sv
// Sequencer and cursor datapath: runs one action at a time as a sequence of states.
module rrce_ctrl #(
  parameter int unsigned RING_BYTES = rrce_pkg::RING_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [2:0]           action,
  input  logic [31:0]          write_length,
  input  logic [31:0]          read_capacity,
  input  logic [63:0]          ticket_in,
  input  logic [63:0]          operation_in,
  input  logic [1:0]           socket_type,
  output logic                 idle,
  output logic                 done,
  output rrce_pkg::result_t    res,
  output logic                 mem_wr_en,
  output logic                 mem_rd_en,
  output logic [$clog2(RING_BYTES)-6:0] mem_addr,
  output logic [$clog2(RING_BYTES)-1:0] mem_wr_len,
  output logic [63:0]          mem_wr_ticket,
  output logic [63:0]          mem_wr_op,
  input  logic [$clog2(RING_BYTES)-1:0] mem_rd_len,
  input  logic [63:0]          mem_rd_ticket,
  input  logic [63:0]          mem_rd_op
);

  localparam int unsigned OFF_W = $clog2(RING_BYTES);
  localparam logic [31:0] RB32   = 32'(RING_BYTES);
  localparam logic [31:0] MAXP   = RB32 - 32'(rrce_pkg::HDR_BYTES);
  localparam logic [31:0] MASK   = RB32 - 32'd1;

  rrce_pkg::state_t state, state_next;

  logic [2:0]       act;
  logic [31:0]      wlen, cap;
  logic [63:0]      tkt, opw;
  logic [31:0]      publish_cursor, consume_cursor;
  logic [OFF_W-1:0] consume_partial;
  logic             sender_closed, receiver_closed;
  logic [31:0]      used;
  logic [31:0]      walk_cursor, walk_left, total;
  logic [OFF_W-1:0] walk_partial;
  logic [31:0]      off, cnt;

  logic        stream, eof;
  logic [31:0] avail, w_cnt0, w_cnt, w_room;
  logic        w_fail;
  rrce_pkg::status_t w_status;
  logic [31:0] len32, part32, remaining, r_cnt, rsz, room, first, second;
  logic        hdr_bad;

  assign stream = socket_type == rrce_pkg::SOCK_STREAM;
  assign eof    = receiver_closed || (used == 32'd0 && sender_closed);
  assign idle   = state == rrce_pkg::S_IDLE;
  assign done   = state == rrce_pkg::S_DONE;

  // Write admission: clip or refuse against the free space.
  always_comb begin
    avail  = RB32 - used;
    w_room = avail - 32'd32;
    w_cnt0 = (wlen > MAXP) ? MAXP : wlen;
    w_cnt  = (w_cnt0 > w_room) ? w_room : w_cnt0;
    w_fail = 1'b1;
    if (used > RB32) begin
      w_status = rrce_pkg::ST_PROTO;
    end else if (sender_closed || receiver_closed) begin
      w_status = rrce_pkg::ST_PIPE;
    end else if (wlen == 32'd0 && stream) begin
      w_status = (tkt != 64'd0) ? rrce_pkg::ST_INVALID : rrce_pkg::ST_OK;
    end else if (!stream && wlen > MAXP) begin
      w_status = rrce_pkg::ST_MSGSIZE;
    end else if (avail < 32'd32 || (wlen != 32'd0 && avail == 32'd32)) begin
      w_status = rrce_pkg::ST_AGAIN;
    end else if (w_cnt0 > w_room && !stream) begin
      w_status = rrce_pkg::ST_AGAIN;
    end else begin
      w_status = rrce_pkg::ST_OK;
      w_fail   = 1'b0;
    end
  end

  // Header check shared by the read and the query walk.
  always_comb begin
    len32     = 32'(mem_rd_len);
    part32    = (state == rrce_pkg::S_RHDR) ? 32'(consume_partial) : 32'(walk_partial);
    rsz       = rrce_pkg::rec_size(len32);
    hdr_bad   = len32 > MAXP || part32 > len32 ||
                rsz > ((state == rrce_pkg::S_RHDR) ? used : walk_left) ||
                (stream && len32 == 32'd0);
    remaining = len32 - part32;
    r_cnt     = (cap < remaining) ? cap : remaining;
    room      = RB32 - off;
    first     = (cnt < room) ? cnt : room;
    second    = cnt - first;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrce_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    mem_wr_en     = 1'b0;
    mem_rd_en     = 1'b0;
    mem_addr      = consume_cursor[OFF_W-1:5];
    mem_wr_len    = w_cnt[OFF_W-1:0];
    mem_wr_ticket = tkt;
    mem_wr_op     = opw;
    unique case (state)
      rrce_pkg::S_IDLE: if (start) state_next = rrce_pkg::S_USED;
      rrce_pkg::S_USED: state_next = rrce_pkg::S_EXEC;
      rrce_pkg::S_EXEC: begin
        state_next = rrce_pkg::S_DONE;
        if (act == rrce_pkg::ACT_WRITE && socket_type != rrce_pkg::SOCK_BAD) begin
          if (!w_fail) begin
            mem_wr_en  = 1'b1;
            mem_addr   = publish_cursor[OFF_W-1:5];
            state_next = rrce_pkg::S_SPAN;
          end
        end else if (act == rrce_pkg::ACT_READ &&
                     socket_type != rrce_pkg::SOCK_BAD) begin
          if (!(used > RB32) && !eof && !(cap == 32'd0 && stream) && used != 32'd0) begin
            mem_rd_en  = 1'b1;
            state_next = rrce_pkg::S_RHDR;
          end
        end else if (act == rrce_pkg::ACT_QUERY &&
                     socket_type != rrce_pkg::SOCK_BAD) begin
          if (!(used > RB32)) begin
            state_next = (receiver_closed || used == 32'd0) ? rrce_pkg::S_QFIN
                                                            : rrce_pkg::S_QREQ;
          end
        end
      end
      rrce_pkg::S_RHDR: begin
        state_next = (hdr_bad || (!stream && consume_partial != '0)) ?
                     rrce_pkg::S_DONE : rrce_pkg::S_SPAN;
      end
      rrce_pkg::S_QREQ: begin
        mem_rd_en  = 1'b1;
        mem_addr   = walk_cursor[OFF_W-1:5];
        state_next = rrce_pkg::S_QHDR;
      end
      rrce_pkg::S_QHDR: begin
        if (hdr_bad) begin
          state_next = rrce_pkg::S_DONE;
        end else if (!stream || walk_left == rsz) begin
          state_next = rrce_pkg::S_QFIN;
        end else begin
          state_next = rrce_pkg::S_QREQ;
        end
      end
      rrce_pkg::S_QFIN: state_next = rrce_pkg::S_DONE;
      rrce_pkg::S_SPAN: state_next = rrce_pkg::S_DONE;
      rrce_pkg::S_DONE: state_next = rrce_pkg::S_IDLE;
      default:          state_next = rrce_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      publish_cursor  <= '0;
      consume_cursor  <= '0;
      consume_partial <= '0;
      sender_closed   <= 1'b0;
      receiver_closed <= 1'b0;
    end else begin
      unique case (state)
        rrce_pkg::S_IDLE: begin
          if (start) begin
            act  <= action;
            wlen <= write_length;
            cap  <= read_capacity;
            tkt  <= ticket_in;
            opw  <= operation_in;
          end
        end
        rrce_pkg::S_USED: begin
          used <= publish_cursor - consume_cursor;
          res  <= '0;
        end
        rrce_pkg::S_EXEC: begin
          if (act == rrce_pkg::ACT_SHUT_TX) begin
            sender_closed <= 1'b1;
            res.status    <= rrce_pkg::ST_OK;
          end else if (act == rrce_pkg::ACT_SHUT_RX) begin
            receiver_closed <= 1'b1;
            res.status      <= rrce_pkg::ST_OK;
          end else if (act > rrce_pkg::ACT_QUERY) begin
            res.status <= rrce_pkg::ST_INVALID;
          end else if (socket_type == rrce_pkg::SOCK_BAD) begin
            res.status <= rrce_pkg::ST_PROTO;
          end else if (act == rrce_pkg::ACT_WRITE) begin
            res.status <= w_status;
            if (!w_fail) begin
              off            <= (publish_cursor + 32'd32) & MASK;
              cnt            <= w_cnt;
              res.byte_count <= w_cnt[12:0];
              publish_cursor <= publish_cursor + rrce_pkg::rec_size(w_cnt);
            end
          end else if (act == rrce_pkg::ACT_READ) begin
            if (used > RB32) begin
              res.status <= rrce_pkg::ST_PROTO;
            end else if (eof) begin
              res.status <= rrce_pkg::ST_OK;
              res.eof    <= 1'b1;
            end else if (cap == 32'd0 && stream) begin
              res.status <= rrce_pkg::ST_OK;
            end else if (used == 32'd0) begin
              res.status <= rrce_pkg::ST_AGAIN;
            end
          end else begin
            if (used > RB32) begin
              res.status <= rrce_pkg::ST_PROTO;
            end
            walk_cursor  <= consume_cursor;
            walk_partial <= consume_partial;
            walk_left    <= used;
            total        <= '0;
          end
        end
        rrce_pkg::S_RHDR: begin
          if (hdr_bad || (!stream && consume_partial != '0)) begin
            res.status <= rrce_pkg::ST_PROTO;
          end else begin
            res.status         <= rrce_pkg::ST_OK;
            off                <= (consume_cursor + 32'd32 + part32) & MASK;
            cnt                <= r_cnt;
            res.byte_count     <= r_cnt[12:0];
            res.ticket_out     <= mem_rd_ticket;
            res.operation_out  <= mem_rd_op;
            res.record_len     <= len32[11:0];
            res.truncated      <= !stream && r_cnt < remaining;
            if (!stream || r_cnt == remaining) begin
              consume_cursor  <= consume_cursor + rsz;
              consume_partial <= '0;
            end else begin
              consume_partial <= OFF_W'(part32 + r_cnt);
            end
          end
        end
        rrce_pkg::S_QREQ: begin
        end
        rrce_pkg::S_QHDR: begin
          if (hdr_bad) begin
            res.status <= rrce_pkg::ST_PROTO;
          end else begin
            total        <= total + remaining;
            walk_cursor  <= walk_cursor + rsz;
            walk_left    <= walk_left - rsz;
            walk_partial <= '0;
          end
        end
        rrce_pkg::S_QFIN: begin
          res.byte_count <= total[12:0];
          res.eof        <= eof;
          res.readable   <= used != 32'd0 || eof;
          if (!stream && wlen > MAXP) begin
            res.status <= rrce_pkg::ST_MSGSIZE;
          end else begin
            res.status   <= rrce_pkg::ST_OK;
            res.writable <= sender_closed || receiver_closed ||
                            (RB32 - used) >= (stream ? 32'd64 : rrce_pkg::rec_size(wlen));
          end
        end
        rrce_pkg::S_SPAN: begin
          res.payload_offset <= off[11:0];
          res.first_span     <= first[11:0];
          res.second_span    <= second[11:0];
        end
        rrce_pkg::S_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/record_ring_cursor_engine_core.sv
// Top level of the record ring cursor engine: handshakes, config and result register.
//
//  channel | direction | signals
//  --------+-----------+--------------------------------------------------
//  in      | input     | in_valid/in_ready, action, write_length,
//          |           | read_capacity, ticket_in, operation_in
//  out     | output    | out_valid/out_ready, status ... writable
//  cfg     | input     | cfg_we, cfg_data (socket_type)
//
// An item runs one at a time through a small sequencer around the header
// memory. Shutdowns and early refusals pass the used, execute and done
// states; writes add a span state, reads a header and a span state, and a
// query a final state plus a request and a header state for every record
// header walked (stream mode walks all queued records). Reset is
// synchronous and clears cursors, close flags and the socket type; the
// header memory needs no clearing. A result waits in the output register
// while out_ready is low; no new item is taken until it leaves.
module record_ring_cursor_engine_core #(
  parameter int unsigned RING_BYTES = rrce_pkg::RING_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [31:0] write_length,
  input  logic [31:0] read_capacity,
  input  logic [63:0] ticket_in,
  input  logic [63:0] operation_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [11:0] payload_offset,
  output logic [11:0] first_span,
  output logic [11:0] second_span,
  output logic [12:0] byte_count,
  output logic [63:0] ticket_out,
  output logic [63:0] operation_out,
  output logic [11:0] record_len,
  output logic        truncated,
  output logic        eof,
  output logic        readable,
  output logic        writable
);

  localparam int unsigned OFF_W  = $clog2(RING_BYTES);
  localparam int unsigned SLOT_W = OFF_W - 5;

  logic [1:0]        socket_type;
  logic              ctrl_idle, ctrl_done;
  rrce_pkg::result_t ctrl_res, res_q;
  logic              mem_wr_en, mem_rd_en;
  logic [SLOT_W-1:0] mem_addr;
  logic [OFF_W-1:0]  mem_wr_len, mem_rd_len;
  logic [63:0]       mem_wr_ticket, mem_wr_op, mem_rd_ticket, mem_rd_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      socket_type <= rrce_pkg::SOCK_STREAM;
    end else if (cfg_we) begin
      socket_type <= cfg_data;
    end
  end

  assign in_ready = ctrl_idle && !out_valid;

  rrce_ctrl #(.RING_BYTES(RING_BYTES)) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (in_valid && in_ready),
    .action        (action),
    .write_length  (write_length),
    .read_capacity (read_capacity),
    .ticket_in     (ticket_in),
    .operation_in  (operation_in),
    .socket_type   (socket_type),
    .idle          (ctrl_idle),
    .done          (ctrl_done),
    .res           (ctrl_res),
    .mem_wr_en     (mem_wr_en),
    .mem_rd_en     (mem_rd_en),
    .mem_addr      (mem_addr),
    .mem_wr_len    (mem_wr_len),
    .mem_wr_ticket (mem_wr_ticket),
    .mem_wr_op     (mem_wr_op),
    .mem_rd_len    (mem_rd_len),
    .mem_rd_ticket (mem_rd_ticket),
    .mem_rd_op     (mem_rd_op)
  );

  rrce_hdr_mem #(.SLOT_W(SLOT_W), .LEN_W(OFF_W)) u_hdr_mem (
    .clk       (clk),
    .wr_en     (mem_wr_en),
    .rd_en     (mem_rd_en),
    .addr      (mem_addr),
    .wr_len    (mem_wr_len),
    .wr_ticket (mem_wr_ticket),
    .wr_op     (mem_wr_op),
    .rd_len    (mem_rd_len),
    .rd_ticket (mem_rd_ticket),
    .rd_op     (mem_rd_op)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_done) begin
      res_q <= ctrl_res;
    end
  end

  assign status         = res_q.status;
  assign payload_offset = res_q.payload_offset;
  assign first_span     = res_q.first_span;
  assign second_span    = res_q.second_span;
  assign byte_count     = res_q.byte_count;
  assign ticket_out     = res_q.ticket_out;
  assign operation_out  = res_q.operation_out;
  assign record_len     = res_q.record_len;
  assign truncated      = res_q.truncated;
  assign eof            = res_q.eof;
  assign readable       = res_q.readable;
  assign writable       = res_q.writable;

  a_done_not_pending: assert property (@(posedge clk) disable iff (rst)
    ctrl_done |-> !out_valid)
    else $error("result finished while previous item still pending");

  a_accept_no_early_out: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid)
    else $error("result shown in cycle after acceptance");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= rrce_pkg::ST_PROTO))
    else $error("status code out of range");

  a_no_write_during_walk: assert property (@(posedge clk) disable iff (rst)
    mem_wr_en |-> !mem_rd_en)
    else $error("header memory read and written together");

endmodule

// File: test/record_ring_cursor_engine_checker.sv
// Checker for the record ring cursor engine: predicts each result and compares it.
module record_ring_cursor_engine_checker
  import rrce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  action,
  input  logic [31:0] write_length,
  input  logic [31:0] read_capacity,
  input  logic [63:0] ticket_in,
  input  logic [63:0] operation_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  status,
  input  logic [11:0] payload_offset,
  input  logic [11:0] first_span,
  input  logic [11:0] second_span,
  input  logic [12:0] byte_count,
  input  logic [63:0] ticket_out,
  input  logic [63:0] operation_out,
  input  logic [11:0] record_len,
  input  logic        truncated,
  input  logic        eof,
  input  logic        readable,
  input  logic        writable,
  input  logic        wrap_up,
  output int          fails,
  output int          pending
);

  localparam logic [31:0] RING = 32'd4096;
  localparam logic [31:0] PAYLOAD_LIMIT = 32'd4064;

  sock_t       sock;
  logic [31:0] pub_cur;
  logic [31:0] con_cur;
  logic [31:0] con_part;
  logic        tx_closed;
  logic        rx_closed;
  logic [11:0] hdr_len [0:127];
  logic [63:0] hdr_ticket [0:127];
  logic [63:0] hdr_op [0:127];
  result_t     awaited_results [$];
  bit          leftover_seen;

  function automatic logic [31:0] footprint(logic [31:0] len);
    return (len + 32'd63) & 32'hffff_ffe0;
  endfunction

  function automatic int slot(logic [31:0] cur);
    return int'((cur >> 5) & 32'd127);
  endfunction

  function automatic result_t with_spans(result_t r, logic [31:0] off, logic [31:0] cnt);
    logic [31:0] room;
    logic [31:0] head;
    room = RING - off;
    head = (cnt < room) ? cnt : room;
    r.payload_offset = off[11:0];
    r.first_span = head[11:0];
    r.second_span = 12'(cnt - head);
    return r;
  endfunction

  function automatic bit hdr_bad(logic [31:0] len, logic [31:0] part, logic [31:0] left);
    return len > PAYLOAD_LIMIT || part > len || footprint(len) > left ||
      (sock == SOCK_STREAM && len == 0);
  endfunction

  // Applies one item to the shadow ring state and returns the result it should give.
  function automatic result_t ring_outcome(logic [2:0] act, logic [31:0] wlen,
                                           logic [31:0] cap, logic [63:0] tk,
                                           logic [63:0] op);
    result_t     r;
    status_t     st;
    logic [31:0] used, avail, cnt, len, rem, cur, part, left, total;
    bit          strm, bad, walking;
    int          s;
    r = '0;
    r.status = ST_OK;
    used = pub_cur - con_cur;
    strm = (sock == SOCK_STREAM);
    if (act == ACT_SHUT_TX) begin
      tx_closed = 1'b1;
    end else if (act == ACT_SHUT_RX) begin
      rx_closed = 1'b1;
    end else if (act > ACT_QUERY) begin
      r.status = ST_INVALID;
    end else if (sock == SOCK_BAD || used > RING) begin
      r.status = ST_PROTO;
    end else if (act == ACT_WRITE) begin
      avail = RING - used;
      if (tx_closed || rx_closed) begin
        r.status = ST_PIPE;
      end else if (wlen == 0 && strm) begin
        if (tk != 0) r.status = ST_INVALID;
      end else if (!strm && wlen > PAYLOAD_LIMIT) begin
        r.status = ST_MSGSIZE;
      end else if (avail < 32 || (wlen != 0 && avail == 32)) begin
        r.status = ST_AGAIN;
      end else begin
        cnt = (wlen > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT : wlen;
        if (cnt > avail - 32) begin
          if (!strm) r.status = ST_AGAIN;
          else cnt = avail - 32;
        end
        if (r.status == ST_OK) begin
          s = slot(pub_cur);
          hdr_len[s] = cnt[11:0];
          hdr_ticket[s] = tk;
          hdr_op[s] = op;
          r = with_spans(r, (pub_cur + 32) & (RING - 1), cnt);
          r.byte_count = cnt[12:0];
          pub_cur = pub_cur + footprint(cnt);
        end
      end
    end else if (act == ACT_READ) begin
      if (rx_closed || (used == 0 && tx_closed)) begin
        r.eof = 1'b1;
      end else if (cap == 0 && strm) begin
        r.status = ST_OK;
      end else if (used == 0) begin
        r.status = ST_AGAIN;
      end else begin
        s = slot(con_cur);
        len = 32'(hdr_len[s]);
        if (hdr_bad(len, con_part, used) || (!strm && con_part != 0)) begin
          r.status = ST_PROTO;
        end else begin
          rem = len - con_part;
          cnt = (cap < rem) ? cap : rem;
          r = with_spans(r, (con_cur + 32 + con_part) & (RING - 1), cnt);
          r.byte_count = cnt[12:0];
          r.ticket_out = hdr_ticket[s];
          r.operation_out = hdr_op[s];
          r.record_len = len[11:0];
          r.truncated = !strm && cnt < rem;
          if (!strm || cnt == rem) begin
            con_cur = con_cur + footprint(len);
            con_part = 0;
          end else begin
            con_part = con_part + cnt;
          end
        end
      end
    end else begin
      // Query: stream mode sums every queued record, packet mode only the head one.
      total = 0;
      bad = 1'b0;
      if (!rx_closed) begin
        cur = con_cur;
        part = con_part;
        left = used;
        walking = (left != 0);
        while (walking) begin
          len = 32'(hdr_len[slot(cur)]);
          if (hdr_bad(len, part, left)) begin
            bad = 1'b1;
            walking = 1'b0;
          end else begin
            total = total + len - part;
            cur = cur + footprint(len);
            left = left - footprint(len);
            part = 0;
            walking = strm && left != 0;
          end
        end
      end
      if (bad) begin
        r.status = ST_PROTO;
      end else begin
        r.eof = rx_closed || (used == 0 && tx_closed);
        r.byte_count = total[12:0];
        r.readable = used != 0 || r.eof;
        if (!strm && wlen > PAYLOAD_LIMIT) begin
          r.status = ST_MSGSIZE;
        end else begin
          r.writable = tx_closed || rx_closed ||
            (RING - used >= (strm ? 32'd64 : footprint(wlen)));
        end
      end
    end
    if (r.status != ST_OK && !(act == ACT_QUERY && r.status == ST_MSGSIZE)) begin
      st = r.status;
      r = '0;
      r.status = st;
    end
    return r;
  endfunction

  task automatic report(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fails++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  initial begin
    fails = 0;
    pending = 0;
    leftover_seen = 1'b0;
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      sock = SOCK_STREAM;
      pub_cur = 0;
      con_cur = 0;
      con_part = 0;
      tx_closed = 1'b0;
      rx_closed = 1'b0;
      awaited_results.delete();
    end else begin
      if (cfg_we) sock = sock_t'(cfg_data);
      if (in_valid && in_ready)
        awaited_results.push_back(ring_outcome(action, write_length, read_capacity,
                                               ticket_in, operation_in));
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report("result arrived with nothing expected");
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 64'(status), 64'(want.status));
          check_field("payload_offset", 64'(payload_offset), 64'(want.payload_offset));
          check_field("first_span", 64'(first_span), 64'(want.first_span));
          check_field("second_span", 64'(second_span), 64'(want.second_span));
          check_field("byte_count", 64'(byte_count), 64'(want.byte_count));
          check_field("ticket_out", ticket_out, want.ticket_out);
          check_field("operation_out", operation_out, want.operation_out);
          check_field("record_len", 64'(record_len), 64'(want.record_len));
          check_field("truncated", 64'(truncated), 64'(want.truncated));
          check_field("eof", 64'(eof), 64'(want.eof));
          check_field("readable", 64'(readable), 64'(want.readable));
          check_field("writable", 64'(writable), 64'(want.writable));
        end
      end
      if (wrap_up && !leftover_seen && awaited_results.size() != 0) begin
        leftover_seen = 1'b1;
        report($sformatf("%0d results never arrived", awaited_results.size()));
      end
    end
    pending = awaited_results.size();
  end

endmodule

// File: test/tb.sv
// Testbench top: clock, reset, stimulus and verdict for the record ring cursor engine.
module tb;
  import rrce_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  action;
  logic [31:0] write_length;
  logic [31:0] read_capacity;
  logic [63:0] ticket_in;
  logic [63:0] operation_in;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic [11:0] payload_offset;
  logic [11:0] first_span;
  logic [11:0] second_span;
  logic [12:0] byte_count;
  logic [63:0] ticket_out;
  logic [63:0] operation_out;
  logic [11:0] record_len;
  logic        truncated;
  logic        eof;
  logic        readable;
  logic        writable;
  logic        wrap_up;
  int          fails;
  int          pending;
  int          burst_left;
  int          quiet_cycles;
  int          stall_mode;
  int          stall_count;

  record_ring_cursor_engine_core i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .action(action),
    .write_length(write_length), .read_capacity(read_capacity),
    .ticket_in(ticket_in), .operation_in(operation_in),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .payload_offset(payload_offset), .first_span(first_span),
    .second_span(second_span), .byte_count(byte_count), .ticket_out(ticket_out),
    .operation_out(operation_out), .record_len(record_len),
    .truncated(truncated), .eof(eof), .readable(readable), .writable(writable)
  );

  record_ring_cursor_engine_checker i_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .action(action),
    .write_length(write_length), .read_capacity(read_capacity),
    .ticket_in(ticket_in), .operation_in(operation_in),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .payload_offset(payload_offset), .first_span(first_span),
    .second_span(second_span), .byte_count(byte_count), .ticket_out(ticket_out),
    .operation_out(operation_out), .record_len(record_len),
    .truncated(truncated), .eof(eof), .readable(readable), .writable(writable),
    .wrap_up(wrap_up), .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The receiver switches between always ready, random stalls and a sparse pattern.
  always @(posedge clk) begin
    stall_count <= stall_count + 1;
    if (stall_count % 64 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      default: out_ready <= (stall_count % 5 == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Presents one item and holds it until it is taken; bursts alternate with gaps.
  task automatic offer_item(logic [2:0] act, logic [31:0] wlen, logic [31:0] cap,
                            logic [63:0] tk, logic [63:0] op);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    action <= act;
    write_length <= wlen;
    read_capacity <= cap;
    ticket_in <= tk;
    operation_in <= op;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic set_socket_type(sock_t kind);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= kind;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic offer_random(bit with_shutdowns);
    logic [2:0]  act;
    logic [31:0] wlen;
    logic [31:0] cap;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 42) act = ACT_WRITE;
    else if (pick < 80) act = ACT_READ;
    else if (pick < 94) act = ACT_QUERY;
    else if (with_shutdowns && pick < 97) act = (pick < 96) ? ACT_SHUT_TX : ACT_SHUT_RX;
    else act = 3'($urandom_range(5, 7));
    pick = $urandom_range(0, 99);
    if (pick < 50) wlen = $urandom_range(0, 200);
    else if (pick < 75) wlen = $urandom_range(0, 4064);
    else if (pick < 85) wlen = $urandom_range(4000, 5000);
    else wlen = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 30) cap = $urandom_range(0, 64);
    else if (pick < 70) cap = $urandom_range(0, 4096);
    else if (pick < 80) cap = 0;
    else cap = $urandom;
    offer_item(act, wlen, cap, ($urandom_range(0, 3) == 0) ? 64'd0 : {$urandom, $urandom},
               {$urandom, $urandom});
  endtask

  initial begin
    sock_t phase_types [7] = '{SOCK_DGRAM, SOCK_SEQPKT, SOCK_STREAM, SOCK_BAD,
                               SOCK_SEQPKT, SOCK_STREAM, SOCK_DGRAM};
    logic [63:0] ones;
    ones = '1;
    rst = 1'b1;
    wrap_up = 1'b0;
    cfg_we = 1'b0;
    cfg_data = SOCK_STREAM;
    in_valid = 1'b0;
    action = ACT_QUERY;
    write_length = '0;
    read_capacity = '0;
    ticket_in = '0;
    operation_in = '0;
    out_ready = 1'b0;
    stall_mode = 0;
    stall_count = 0;
    quiet_cycles = 0;
    burst_left = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Stream mode straight after reset: empty ring, zero lengths, clipping, partial reads.
    set_socket_type(SOCK_STREAM);
    offer_item(ACT_QUERY, 0, 0, 0, 0);
    offer_item(ACT_READ, 0, 5, 0, 0);
    offer_item(ACT_READ, 0, 0, 0, 0);
    offer_item(ACT_WRITE, 0, 0, 0, 0);
    offer_item(ACT_WRITE, 0, 0, 64'd1, 0);
    offer_item(ACT_WRITE, 100, 0, ones, ones);
    offer_item(ACT_WRITE, 32'hffff_ffff, 0, 64'h5a5a_0f0f_1234_8765, ones);
    offer_item(ACT_QUERY, 0, 0, 0, 0);
    offer_item(ACT_WRITE, 1, 0, 1, 1);
    offer_item(ACT_READ, 0, 10, 0, 0);
    offer_item(ACT_READ, 0, 32'hffff_ffff, 0, 0);
    offer_item(ACT_READ, 0, 32'hffff_ffff, 0, 0);
    offer_item(5, 0, 0, 0, 0);
    offer_item(6, 0, 0, 0, 0);
    offer_item(7, 0, 0, 0, 0);
    offer_item(ACT_WRITE, 4064, 0, ones, 0);
    offer_item(ACT_READ, 0, 4096, 0, 0);

    // Datagram mode: oversize, exact fit, no room, truncation, zero length.
    set_socket_type(SOCK_DGRAM);
    offer_item(ACT_WRITE, 5000, 0, 0, 0);
    offer_item(ACT_WRITE, 4064, 0, 7, 9);
    offer_item(ACT_QUERY, 4065, 0, 0, 0);
    offer_item(ACT_WRITE, 10, 0, 0, 0);
    offer_item(ACT_READ, 0, 3, 0, 0);
    offer_item(ACT_WRITE, 0, 0, 3, 4);
    offer_item(ACT_READ, 0, 0, 0, 0);

    foreach (phase_types[p]) begin
      set_socket_type(phase_types[p]);
      repeat (105) offer_random(1'b0);
    end

    // Closing both sides is permanent, so it only happens in the last phase.
    set_socket_type(SOCK_STREAM);
    repeat (40) offer_random(1'b0);
    offer_item(ACT_SHUT_TX, 0, 0, 0, 0);
    repeat (40) offer_random(1'b1);
    offer_item(ACT_SHUT_RX, 0, 0, 0, 0);
    repeat (15) offer_random(1'b1);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    wrap_up <= 1'b1;
    repeat (2) @(posedge clk);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
